@@ rtl/assert_macros.svh @@
// Assertion macros shared by the RTL of the multi-queue ring FIFO.
// Each macro samples on clk_i and is disabled while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge.
`define MQRF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Antecedent at one edge implies the consequent at the next edge.
`define MQRF_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/mqrf_pkg.sv @@
// Package of the multi-queue ring FIFO: field widths, stream packing,
// register indexes, operation codes and the controller state type. No dependencies.
package mqrf_pkg;

  // Default build parameters.
  localparam int NUM_QUEUES_DEF    = 4;
  localparam int MAX_DEPTH_DEF     = 32;
  localparam int ELEMENT_BYTES_DEF = 4;

  // Field widths of the input and result words.
  localparam int MODE_W  = 3;
  localparam int QUEUE_W = 3;
  localparam int DATA_W  = 32;
  localparam int COUNT_W = 6;
  localparam int LEVEL_W = 6;

  // Stream packing, first field in the lowest bits, padded to whole bytes.
  localparam int IN_FIELDS_W  = MODE_W + QUEUE_W + DATA_W + COUNT_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = DATA_W + LEVEL_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int USER_W       = 2;
  localparam int USER_STATUS  = 0;
  localparam int USER_HAS_DATA = 1;

  // Configuration port.
  localparam int CFG_AW         = 3;
  localparam int CFG_DW         = 3;
  localparam int N_DEPTH_REGS   = 4;
  localparam int DREG_W         = 2;
  localparam int CFG_ACTIVE     = 0;
  localparam int CFG_DEPTH_BASE = 1;

  // Most result words that one input word may cause.
  localparam int RESULT_LIMIT = 32;

  // Operation codes carried in the mode field.
  typedef enum logic [MODE_W-1:0] {
    MODE_PUSH      = 3'd0,
    MODE_POP       = 3'd1,
    MODE_PEEK      = 3'd2,
    MODE_POP_MANY  = 3'd3,
    MODE_PEEK_MANY = 3'd4,
    MODE_LEVEL     = 3'd5
  } mode_e;

  // Controller states, one-hot.
  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_READ = 2'b10
  } state_e;

endpackage

@@ rtl/mqrf_store.sv @@
// Element store of the multi-queue ring FIFO: one write port and one read port,
// read data registered. No dependencies.
module mqrf_store #(
  parameter int EW    = 32,
  parameter int AW    = 7,
  parameter int DEPTH = 128
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [EW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [EW-1:0] rdata_o
);

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/multi_queue_ring_fifo.sv @@
// Top level of the multi-queue ring FIFO: queue pointers, configuration and control.
// Depends on mqrf_pkg, mqrf_store and assert_macros.svh.
//
// NUM_QUEUES ring FIFOs share one element store, queue q owning the slots from
// q*MAX_DEPTH up. Each input word performs one operation on one queue (push, pop,
// peek, pop many, peek many, level query) and causes one or more result words,
// the final one marked by tlast. A push, a level query and every error answer give
// a single result word. Pops and peeks read the store, which has a single read
// port with registered read data and delivers one element per cycle while the
// output register is free or being emptied, and no new word is taken while
// elements are being read out. Results are held in an output register, so a new
// word is accepted while the previous result waits, as long as that register is
// free or being emptied. Writing a depth register clears that queue's pointers;
// the store needs no clearing after reset. Configure only while the block is idle.
module multi_queue_ring_fifo #(
  parameter int NUM_QUEUES    = mqrf_pkg::NUM_QUEUES_DEF,
  parameter int MAX_DEPTH     = mqrf_pkg::MAX_DEPTH_DEF,
  parameter int ELEMENT_BYTES = mqrf_pkg::ELEMENT_BYTES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // Configuration write port
  input  logic                             cfg_we_i,
  input  logic [mqrf_pkg::CFG_AW-1:0]      cfg_addr_i,
  input  logic [mqrf_pkg::CFG_DW-1:0]      cfg_data_i,
  // Input words
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // mode[2:0], queue[5:3], push_data[37:6], count[43:38], zero pad
  input  logic [mqrf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  // Result words
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // read_data[31:0], level[37:32], zero pad
  output logic [mqrf_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  // status[0], has_data[1]
  output logic [mqrf_pkg::USER_W-1:0]      m_axis_tuser,
  output logic                             m_axis_tlast
);
  import mqrf_pkg::*;

  localparam int DL     = $clog2(MAX_DEPTH + 1) - 1;  // log2 of the largest depth
  localparam int PW     = DL + 1;                      // pointer and level width
  localparam int QW     = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int SLOTS  = NUM_QUEUES * MAX_DEPTH;
  localparam int AW     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int EW_RAW = 8 * ELEMENT_BYTES;
  localparam int EW     = (EW_RAW > DATA_W) ? DATA_W : EW_RAW;

  // Input word fields.
  logic [MODE_W-1:0]  in_mode;
  logic [QUEUE_W-1:0] in_queue;
  logic [DATA_W-1:0]  in_data;
  logic [COUNT_W-1:0] in_count;

  assign in_mode  = s_axis_tdata[MODE_W-1:0];
  assign in_queue = s_axis_tdata[MODE_W +: QUEUE_W];
  assign in_data  = s_axis_tdata[MODE_W + QUEUE_W +: DATA_W];
  assign in_count = s_axis_tdata[MODE_W + QUEUE_W + DATA_W +: COUNT_W];

  // Configuration and pointer state.
  logic [CFG_DW-1:0] active_q;
  logic [CFG_DW-1:0] depth_q [N_DEPTH_REGS];
  logic [PW-1:0]     wptr_q  [NUM_QUEUES];
  logic [PW-1:0]     rptr_q  [NUM_QUEUES];

  // Controller and output register.
  state_e             state_q, state_d;
  logic               m_valid_q;
  logic [COUNT_W-1:0] rem_q;
  logic [QW-1:0]      rq_q;
  logic [PW-1:0]      ramask_q;
  logic [PW-1:0]      rcur_q;
  logic [PW-1:0]      rlvl_q;
  logic               out_status_q;
  logic               out_has_data_q;
  logic [DATA_W-1:0]  out_data_q;
  logic               out_last_q;
  logic [LEVEL_W-1:0] out_level_q;

  // Store ports.
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic          mem_re;
  logic [AW-1:0] mem_raddr;
  logic [EW-1:0] mem_rdata;

  // Address of a pointer's slot in the store.
  function automatic logic [AW-1:0] slot_addr(input logic [QW-1:0] q,
                                              input logic [PW-1:0] ptr,
                                              input logic [PW-1:0] amask);
    slot_addr = AW'(q) * AW'(MAX_DEPTH) + AW'(ptr & amask);
  endfunction

  // Handshake.
  logic out_free, accept, rd_load, rd_more;

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign rd_load       = (state_q == S_READ) && out_free;
  assign rd_more       = rd_load && (rem_q != COUNT_W'(1));

  // View of the addressed queue.
  logic              qv;
  logic [QW-1:0]     qi;
  logic [CFG_DW-1:0] dreg, dl;
  logic [PW-1:0]     dep, amask, pmask, wp, rp, lvl;
  logic              full, empty, cnt_err;

  always_comb begin
    qv      = (4'(in_queue) < 4'(active_q)) && (4'(in_queue) < 4'(NUM_QUEUES));
    qi      = qv ? in_queue[QW-1:0] : '0;
    dreg    = depth_q[in_queue[DREG_W-1:0]];
    dl      = (dreg > CFG_DW'(DL)) ? CFG_DW'(DL) : dreg;
    dep     = PW'(1) << dl;
    amask   = dep - PW'(1);
    pmask   = (dep << 1) - PW'(1);
    wp      = wptr_q[qi];
    rp      = rptr_q[qi];
    lvl     = (wp - rp) & pmask;
    full    = lvl >= dep;
    empty   = lvl == '0;
    cnt_err = empty || (8'(in_count) > 8'(lvl)) || (in_count > COUNT_W'(RESULT_LIMIT));
  end

  // Decode of the accepted word.
  logic               start_rd, imm_st, wp_upd, rp_upd, push_we;
  logic [PW-1:0]      imm_lvl, rd_lvl, rp_nxt;
  logic [COUNT_W-1:0] rd_rem;

  always_comb begin
    start_rd = 1'b0;
    imm_st   = 1'b1;
    imm_lvl  = lvl;
    wp_upd   = 1'b0;
    rp_upd   = 1'b0;
    push_we  = 1'b0;
    rd_lvl   = lvl;
    rd_rem   = COUNT_W'(1);
    rp_nxt   = rp;
    if (!qv) begin
      imm_lvl = '0;
    end else begin
      case (in_mode)
        MODE_PUSH: begin
          if (!full) begin
            imm_st  = 1'b0;
            wp_upd  = 1'b1;
            push_we = 1'b1;
            imm_lvl = lvl + PW'(1);
          end
        end
        MODE_POP, MODE_PEEK: begin
          if (!empty) begin
            start_rd = 1'b1;
            if (in_mode == MODE_POP) begin
              rp_upd = 1'b1;
              rp_nxt = (rp + PW'(1)) & pmask;
              rd_lvl = lvl - PW'(1);
            end
          end
        end
        MODE_POP_MANY, MODE_PEEK_MANY: begin
          if (!cnt_err) begin
            if (in_count == '0) begin
              imm_st = 1'b0;
            end else begin
              start_rd = 1'b1;
              rd_rem   = in_count;
              if (in_mode == MODE_POP_MANY) begin
                rp_upd = 1'b1;
                rp_nxt = (rp + PW'(in_count)) & pmask;
                rd_lvl = lvl - PW'(in_count);
              end
            end
          end
        end
        MODE_LEVEL: begin
          imm_st = 1'b0;
        end
        default: begin
          imm_st = 1'b1;
        end
      endcase
    end
  end

  // Store access: pushes write at acceptance, reads start at acceptance and continue
  // one element per cycle, while the output register is free, from the saved cursor.
  assign mem_we    = accept && push_we;
  assign mem_waddr = slot_addr(qi, wp, amask);
  assign mem_re    = (accept && start_rd) || rd_more;
  assign mem_raddr = (state_q == S_IDLE) ? slot_addr(qi, rp, amask)
                                         : slot_addr(rq_q, rcur_q, ramask_q);

  mqrf_store #(
    .EW    (EW),
    .AW    (AW),
    .DEPTH (SLOTS)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (in_data[EW-1:0]),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept && start_rd) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (rd_load && (rem_q == COUNT_W'(1))) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state, configuration registers and queue pointers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      m_valid_q <= 1'b0;
      rem_q     <= '0;
      active_q  <= '0;
      for (int i = 0; i < N_DEPTH_REGS; i++) begin
        depth_q[i] <= '0;
      end
      for (int j = 0; j < NUM_QUEUES; j++) begin
        wptr_q[j] <= '0;
        rptr_q[j] <= '0;
      end
    end else begin
      state_q <= state_d;

      // Output register occupancy.
      if (accept && !start_rd) begin
        m_valid_q <= 1'b1;
      end else if (rd_load) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end

      // Elements left to deliver.
      if (accept && start_rd) begin
        rem_q <= rd_rem;
      end else if (rd_load) begin
        rem_q <= rem_q - COUNT_W'(1);
      end

      // Configuration writes; a depth write clears that queue's pointers.
      if (cfg_we_i) begin
        if (cfg_addr_i == CFG_AW'(CFG_ACTIVE)) begin
          active_q <= cfg_data_i;
        end
        for (int i = 0; i < N_DEPTH_REGS; i++) begin
          if (cfg_addr_i == CFG_AW'(CFG_DEPTH_BASE + i)) begin
            depth_q[i] <= cfg_data_i;
          end
        end
        for (int j = 0; j < NUM_QUEUES; j++) begin
          if ((j < N_DEPTH_REGS) && (cfg_addr_i == CFG_AW'(CFG_DEPTH_BASE + j))) begin
            wptr_q[j] <= '0;
            rptr_q[j] <= '0;
          end
        end
      end else if (accept) begin
        if (wp_upd) begin
          wptr_q[qi] <= (wp + PW'(1)) & pmask;
        end
        if (rp_upd) begin
          rptr_q[qi] <= rp_nxt;
        end
      end
    end
  end

  // Read cursor and result payload.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rq_q     <= qi;
      ramask_q <= amask;
      rcur_q   <= rp + PW'(1);
      rlvl_q   <= rd_lvl;
      if (!start_rd) begin
        out_status_q   <= imm_st;
        out_has_data_q <= 1'b0;
        out_data_q     <= '0;
        out_last_q     <= 1'b1;
        out_level_q    <= LEVEL_W'(imm_lvl);
      end
    end else if (rd_load) begin
      out_status_q   <= 1'b0;
      out_has_data_q <= 1'b1;
      out_data_q     <= DATA_W'(mem_rdata);
      out_last_q     <= (rem_q == COUNT_W'(1));
      out_level_q    <= LEVEL_W'(rlvl_q);
      if (rd_more) begin
        rcur_q <= rcur_q + PW'(1);
      end
    end
  end

  // Result word.
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({out_level_q, out_data_q});
  assign m_axis_tuser  = {out_has_data_q, out_status_q};
  assign m_axis_tlast  = out_last_q;

  // Checks on the controller.
`include "assert_macros.svh"

  `MQRF_ASSERT(a_busy_not_ready, (state_q != S_READ) || !s_axis_tready, "ready while reading out")
  `MQRF_ASSERT(a_read_has_work, (state_q != S_READ) || (rem_q != '0), "read-out with no elements left")
  `MQRF_ASSERT_NEXT(a_load_has_data, rd_load, m_axis_tvalid && m_axis_tuser[USER_HAS_DATA] && !m_axis_tuser[USER_STATUS], "element word missing its data flag")
  `MQRF_ASSERT_NEXT(a_final_marks_last, rd_load && (rem_q == COUNT_W'(1)), (state_q == S_IDLE) && m_axis_tlast, "final element not marked last")

endmodule
